// ===== rtl/core/sfm_pkg.sv =====
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types, constants and the table-building function for the STFT
// magnitude block.
// ----------------------------------------------------------------------------
package sfm_pkg;

   localparam int FFT_POINTS_DEF    = 64;
   localparam int WINDOW_LENGTH_DEF = 64;
   localparam int ADDR_W            = 10;
   localparam int CNT_W             = 11;
   localparam int HOP_W             = 7;
   localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;
   localparam logic [21:0] MAG_MAX  = 22'h3FFFFF;
   localparam int CORDIC_STEPS      = 16;

   localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last_sample;
   } req_type;

   typedef struct packed {
      logic [15:0] frame_index;
      logic [5:0]  bin_index;
      logic [21:0] magnitude;
      logic        last_bin;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [CNT_W-1:0]  count;
      logic [15:0]       frame;
   } cmd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       data;
   } hist_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_COPY, ST_MAC, ST_ROUND, ST_SQ_RE, ST_SQ_IM, ST_SQRT, ST_EMIT
   } back_state_type;

   // Returns {cos, sin} in Q3.15 (18-bit signed each) for a phase in 2^-32 turns.
   function automatic logic [35:0] sfm_cos_sin(input logic [31:0] phase);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint cq;
      longint sq;
      logic signed [17:0] c;
      logic signed [17:0] s;
      x = 652032874;
      y = 0;
      z = longint'(phase & 32'h3FFFFFFF);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURNS[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURNS[i];
         end
      end
      cq = (x + 16384) >>> 15;
      sq = (y + 16384) >>> 15;
      case (phase[31:30])
         2'd0: begin
            c = 18'(cq);
            s = 18'(sq);
         end
         2'd1: begin
            c = 18'(-sq);
            s = 18'(cq);
         end
         2'd2: begin
            c = 18'(-cq);
            s = 18'(-sq);
         end
         default: begin
            c = 18'(sq);
            s = 18'(-cq);
         end
      endcase
      return {c, s};
   endfunction

endpackage

// ===== rtl/core/stft_magnitude_frames.sv =====
// ----------------------------------------------------------------------------
// stft_magnitude_frames
// Streaming STFT magnitude with a periodic Hann window.
// ----------------------------------------------------------------------------
// One sample word enters on the req_ channel; last_sample ends a clip and
// restarts the clip counters. A sample that completes no frame queues no
// command and so does not lower req_ready. When a frame is due, the front
// queues a frame command; the back takes it from the queue once it is idle
// and copies the windowed history into its workspace, then computes every
// bin from 0 to FFT_POINTS/2. Each bin runs a multiply-accumulate on two
// multipliers, then rounding and squaring, the serial square root with one
// root bit per cycle (ACC_W - 15 bits) and a load of the output register.
// While a frame command waits or its window is being copied, req_ready is
// low. Results leave on the rsp_ channel, one word per bin, through an output
// register; a stalled receiver holds the back at its next bin while the
// front keeps taking samples until the next frame is due. The csr_ port
// writes the hop size and is always ready. Synchronous reset sets the hop
// size to 16 and clears the clip counters, the write pointer and the queue.
// ----------------------------------------------------------------------------
module stft_magnitude_frames
   import sfm_pkg::*;
#(
   parameter int FFT_POINTS    = FFT_POINTS_DEF,
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [HOP_W-1:0] csr_data
);

   logic        queue_empty;
   logic        queue_full;
   logic        copy_busy;
   logic        cmd_push;
   logic        cmd_pop;
   cmd_type     cmd_in;
   cmd_type     cmd_out;
   hist_wr_type hist_wr;

   assign csr_ready = 1'b1;

   sfm_front #(
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .queue_empty(queue_empty),
      .copy_busy  (copy_busy),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in),
      .hist_wr    (hist_wr)
   );

   sfm_cmd_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_in),
      .pop      (cmd_pop),
      .pop_data (cmd_out),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   sfm_back #(
      .FFT_POINTS   (FFT_POINTS),
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .hist_wr    (hist_wr),
      .queue_empty(queue_empty),
      .cmd_data   (cmd_out),
      .cmd_pop    (cmd_pop),
      .copy_busy  (copy_busy),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_one_frame_pending: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !req_ready)
      else $error("Samples accepted while a frame command is pending.");

endmodule

// ===== rtl/core/sfm_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sfm_cmd_fifo
// Two-entry queue of frame commands between the front and the back.
// ----------------------------------------------------------------------------
module sfm_cmd_fifo
   import sfm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty,
   output logic    full
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop) else $error("Command pushed into a full queue.");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("Command popped from an empty queue.");

endmodule

// ===== rtl/core/sfm_front.sv =====
// ----------------------------------------------------------------------------
// sfm_front
// Accepts samples, keeps the clip counters and the hop register, writes the
// sample history and issues a frame command when a frame is due.
// ----------------------------------------------------------------------------
module sfm_front
   import sfm_pkg::*;
#(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic             csr_valid,
   input  logic [HOP_W-1:0] csr_data,
   input  logic             queue_empty,
   input  logic             copy_busy,
   output logic             cmd_push,
   output cmd_type          cmd_data,
   output hist_wr_type      hist_wr
);

   localparam int HW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam logic [15:0] W16 = 16'(WINDOW_LENGTH);
   localparam logic [HW:0] W_EXT = (HW+1)'(WINDOW_LENGTH);

   logic [HOP_W-1:0] hop_ff;
   logic [HOP_W-1:0] hop_in;
   logic [15:0]      seen_ff;
   logic [15:0]      seen_in;
   logic [HOP_W-1:0] cd_ff;
   logic [HOP_W-1:0] cd_in;
   logic [15:0]      frames_ff;
   logic [15:0]      frames_in;
   logic [HW-1:0]    wp_ff;
   logic [HW-1:0]    wp_in;

   logic             accept;
   logic [15:0]      seen_inc;
   logic [HOP_W-1:0] cd_dec;
   logic [HOP_W-1:0] cd_step;
   logic             fire;
   logic             pad;
   logic [HW:0]      pad_off;
   logic [HW:0]      pad_sum;
   logic [HW-1:0]    pad_base;

   assign req_ready = queue_empty && !copy_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      hop_in   = csr_valid ? csr_data : hop_ff;
      seen_inc = (seen_ff == 16'hFFFF) ? seen_ff : seen_ff + 16'd1;
      cd_dec   = (cd_ff != '0) ? cd_ff - 1'b1 : cd_ff;
      wp_in    = (wp_ff == HW'(WINDOW_LENGTH - 1)) ? '0 : wp_ff + 1'b1;
      if (seen_inc == W16) begin
         fire    = 1'b1;
         cd_step = cd_ff;
      end else if (seen_inc > W16) begin
         fire    = (cd_dec == '0);
         cd_step = cd_dec;
      end else begin
         fire    = 1'b0;
         cd_step = cd_ff;
      end
      if (fire) begin
         cd_step = (hop_ff == '0) ? HOP_W'(1) : hop_ff;
      end
      pad      = !fire && req_data.last_sample && (seen_inc < W16);
      pad_off  = W_EXT - (HW+1)'(seen_inc);
      pad_sum  = {1'b0, wp_in} + pad_off;
      pad_base = (pad_sum >= W_EXT) ? HW'(pad_sum - W_EXT) : pad_sum[HW-1:0];

      seen_in   = seen_ff;
      cd_in     = cd_ff;
      frames_in = frames_ff;
      if (accept) begin
         if (req_data.last_sample) begin
            seen_in   = '0;
            cd_in     = '0;
            frames_in = '0;
         end else begin
            seen_in   = seen_inc;
            cd_in     = cd_step;
            frames_in = frames_ff + 16'(fire);
         end
      end

      cmd_push       = accept && (fire || pad);
      cmd_data.base  = ADDR_W'(fire ? wp_in : pad_base);
      cmd_data.count = fire ? CNT_W'(WINDOW_LENGTH) : CNT_W'(seen_inc);
      cmd_data.frame = frames_ff;

      hist_wr.en   = accept;
      hist_wr.addr = ADDR_W'(wp_ff);
      hist_wr.data = req_data.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_ff    <= HOP_RESET;
         seen_ff   <= '0;
         cd_ff     <= '0;
         frames_ff <= '0;
         wp_ff     <= '0;
      end else begin
         hop_ff    <= hop_in;
         seen_ff   <= seen_in;
         cd_ff     <= cd_in;
         frames_ff <= frames_in;
         if (accept) begin
            wp_ff <= wp_in;
         end
      end
   end

endmodule

// ===== rtl/core/sfm_back.sv =====
// ----------------------------------------------------------------------------
// sfm_back
// Holds the sample history, windows a frame into the workspace and computes
// each bin by a direct DFT, a squared sum and a bit-serial square root.
// ----------------------------------------------------------------------------
module sfm_back
   import sfm_pkg::*;
#(
   parameter int FFT_POINTS    = FFT_POINTS_DEF,
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  hist_wr_type hist_wr,
   input  logic        queue_empty,
   input  cmd_type     cmd_data,
   output logic        cmd_pop,
   output logic        copy_busy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int HW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int TW    = $clog2(FFT_POINTS);
   localparam int IW    = $clog2(FFT_POINTS + 1);
   localparam int HALF  = FFT_POINTS / 2;
   localparam int KW    = $clog2(HALF + 1);
   localparam int ACC_W = 34 + TW;
   localparam int R_W   = ACC_W - 15;
   localparam int SCW   = $clog2(R_W + 1);

   logic signed [17:0] cos_tab [FFT_POINTS];
   logic signed [17:0] sin_tab [FFT_POINTS];
   logic [16:0]        hann_tab [WINDOW_LENGTH];

   for (genvar g = 0; g < FFT_POINTS; g++) begin : g_twiddle
      localparam longint PH = (longint'(g) << 32) / FFT_POINTS;
      localparam logic [35:0] CS = sfm_cos_sin(PH[31:0]);
      assign cos_tab[g] = CS[35:18];
      assign sin_tab[g] = CS[17:0];
   end

   for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_hann
      localparam longint PH = (longint'(g) << 32) / WINDOW_LENGTH;
      localparam logic [35:0] CS = sfm_cos_sin(PH[31:0]);
      localparam longint HV = (32769 - longint'($signed(CS[35:18]))) >>> 1;
      assign hann_tab[g] = HV[16:0];
   end

   back_state_type state_ff;
   back_state_type state_in;

   logic signed [15:0] hist_mem_ff [WINDOW_LENGTH];
   logic signed [15:0] ws_mem_ff [FFT_POINTS];

   logic [HW-1:0]      hptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [15:0]        frame_ff;
   logic [IW-1:0]      i_ff;
   logic [TW-1:0]      t_ff;
   logic [KW-1:0]      k_ff;

   logic signed [15:0] hist_rd_ff;
   logic               s1_vld_ff;
   logic [TW-1:0]      s1_idx_ff;
   logic               s1_keep_ff;

   logic signed [15:0] ws_rd_ff;
   logic               m1_vld_ff;
   logic [TW-1:0]      m1_t_ff;
   logic signed [33:0] prod_re_ff;
   logic signed [33:0] prod_im_ff;
   logic               m2_vld_ff;
   logic signed [ACC_W-1:0] acc_re_ff;
   logic signed [ACC_W-1:0] acc_im_ff;

   logic signed [R_W-1:0] r15_re_ff;
   logic signed [R_W-1:0] r15_im_ff;
   logic [2*R_W-1:0]      rad_ff;
   logic [R_W+1:0]        rem_ff;
   logic [R_W-1:0]        root_ff;
   logic [SCW-1:0]        sq_cnt_ff;

   logic    out_valid_ff;
   rsp_type out_data_ff;

   logic               issue_busy;
   logic               copy_done;
   logic               mac_done;
   logic               out_free;
   logic               out_load;
   logic               last_bin;
   logic signed [33:0] win_prod;
   logic signed [33:0] win_sum;
   logic signed [15:0] win_val;
   logic [TW:0]        t_sum;
   logic [TW-1:0]      t_next;
   logic signed [R_W-1:0]   sq_op;
   logic signed [2*R_W-1:0] sq_val;
   logic [R_W+1:0]     rem_sh;
   logic [R_W+1:0]     trial;
   logic [R_W-1:0]     mag_full;
   logic [ACC_W-1:0]   round_re;
   logic [ACC_W-1:0]   round_im;

   assign issue_busy = (i_ff != IW'(FFT_POINTS));
   assign copy_done  = !issue_busy && !s1_vld_ff;
   assign mac_done   = !issue_busy && !m1_vld_ff && !m2_vld_ff;
   assign out_free   = !out_valid_ff || rsp_ready;
   assign last_bin   = (k_ff == KW'(HALF));
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (copy_done) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: state_in = ST_SQ_RE;
         ST_SQ_RE: state_in = ST_SQ_IM;
         ST_SQ_IM: state_in = ST_SQRT;
         ST_SQRT: begin
            if (sq_cnt_ff == SCW'(R_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = last_bin ? ST_IDLE : ST_MAC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = (state_ff == ST_IDLE) && !queue_empty;
      copy_busy = (state_ff == ST_COPY);
      out_load  = (state_ff == ST_EMIT) && out_free;
   end

   always_comb begin
      win_prod = hist_rd_ff * $signed({1'b0, hann_tab[HW'(s1_idx_ff)]});
      win_sum  = win_prod + 34'sd16384;
      win_val  = win_sum[30:15];
      t_sum    = {1'b0, t_ff} + (TW+1)'(k_ff);
      t_next   = (t_sum >= (TW+1)'(FFT_POINTS)) ?
                 TW'(t_sum - (TW+1)'(FFT_POINTS)) : t_sum[TW-1:0];
      round_re = acc_re_ff + ACC_W'(16384);
      round_im = acc_im_ff + ACC_W'(16384);
      sq_op    = (state_ff == ST_SQ_RE) ? r15_re_ff : r15_im_ff;
      sq_val   = sq_op * sq_op;
      rem_sh   = {rem_ff[R_W-1:0], rad_ff[2*R_W-1 -: 2]};
      trial    = {root_ff, 2'b01};
      mag_full = root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         m1_vld_ff    <= 1'b0;
         m2_vld_ff    <= 1'b0;
         i_ff         <= IW'(FFT_POINTS);
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         s1_vld_ff <= (state_ff == ST_COPY) && issue_busy;
         m1_vld_ff <= (state_ff == ST_MAC) && issue_busy;
         m2_vld_ff <= m1_vld_ff;
         if (cmd_pop) begin
            i_ff <= '0;
         end else if ((state_ff == ST_COPY || state_ff == ST_MAC) && issue_busy) begin
            i_ff <= i_ff + 1'b1;
         end else if ((state_ff == ST_COPY && copy_done) || (out_load && !last_bin)) begin
            i_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hist_wr.en) begin
         hist_mem_ff[HW'(hist_wr.addr)] <= hist_wr.data;
      end
      hist_rd_ff <= hist_mem_ff[hptr_ff];
      if (s1_vld_ff) begin
         ws_mem_ff[s1_idx_ff] <= s1_keep_ff ? win_val : 16'sd0;
      end
      ws_rd_ff <= ws_mem_ff[TW'(i_ff)];
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         hptr_ff  <= HW'(cmd_data.base);
         count_ff <= cmd_data.count;
         frame_ff <= cmd_data.frame;
      end
      if (state_ff == ST_COPY && issue_busy) begin
         hptr_ff    <= (hptr_ff == HW'(WINDOW_LENGTH - 1)) ? '0 : hptr_ff + 1'b1;
         s1_idx_ff  <= TW'(i_ff);
         s1_keep_ff <= (12'(i_ff) < 12'(count_ff)) && (12'(i_ff) < 12'(WINDOW_LENGTH));
      end
      if (state_ff == ST_MAC && issue_busy) begin
         m1_t_ff <= t_ff;
         t_ff    <= t_next;
      end
      prod_re_ff <= ws_rd_ff * cos_tab[m1_t_ff];
      prod_im_ff <= ws_rd_ff * sin_tab[m1_t_ff];
      if (m2_vld_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(prod_re_ff);
         acc_im_ff <= acc_im_ff - ACC_W'(prod_im_ff);
      end
      if ((state_ff == ST_COPY && copy_done) || (out_load && !last_bin)) begin
         t_ff      <= '0;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         k_ff      <= (state_ff == ST_COPY) ? '0 : k_ff + 1'b1;
      end
      case (state_ff)
         ST_ROUND: begin
            r15_re_ff <= round_re[ACC_W-1:15];
            r15_im_ff <= round_im[ACC_W-1:15];
         end
         ST_SQ_RE: rad_ff <= sq_val;
         ST_SQ_IM: begin
            rad_ff    <= rad_ff + sq_val;
            rem_ff    <= '0;
            root_ff   <= '0;
            sq_cnt_ff <= '0;
         end
         ST_SQRT: begin
            rad_ff    <= {rad_ff[2*R_W-3:0], 2'b00};
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[R_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[R_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_data_ff.frame_index <= frame_ff;
         out_data_ff.bin_index   <= 6'(k_ff);
         out_data_ff.magnitude   <= (mag_full > R_W'(MAG_MAX)) ? MAG_MAX : mag_full[21:0];
         out_data_ff.last_bin    <= last_bin;
      end
   end

   a_hist_quiet_in_copy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> !hist_wr.en)
      else $error("History written while a frame is being copied.");
   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_ready))
      else $error("Result register overwritten before it was taken.");

endmodule
